// ===== hdl/losoc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// losoc_pkg
// Shared types and constants for the line-of-sight obstacle check core.
// ----------------------------------------------------------------------------
package losoc_pkg;

    localparam int MAX_WALLS  = 256;
    localparam int COORD_BITS = 20;

    localparam int ADDR_W = $clog2(MAX_WALLS);
    localparam int CNT_W  = $clog2(MAX_WALLS + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int WALL_W = 4 * COORD_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/line_of_sight_obstacle_check_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_of_sight_obstacle_check_core
// Wall segment table with a pipelined segment crossing scan.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_ channel carries an op and two points A and B.
// Clear empties the wall table, append stores wall A-B, query asks whether
// segment A-B crosses any stored wall. Every beat yields one m_ beat with
// visible, degenerate, table_full and the wall count after the beat.
// Clear and append (and the unused op code) answer in the cycle after the
// beat is taken. A query with N walls stored streams the walls out of the
// wall memory one per cycle into a four stage crossing pipeline; the scan
// ends when every stored wall has left the pipeline, or at once on a
// crossing, and the result goes to the output register once it is free;
// the memory read port sets that one wall per cycle pace. At most one
// item is in the block at a time; s_ready is high in idle while the output
// register is empty or being emptied. A stall on m_ready holds the result
// in the output register and keeps s_ready low after a query finishes.
// Reset (aresetn low, synchronous) empties the table and drops any beat
// in flight; the wall memory itself is not cleared, entries past the count
// are never read.
// ----------------------------------------------------------------------------
module line_of_sight_obstacle_check_core
    import losoc_pkg::*;
(
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [1:0]                   s_op,
    input  wire  signed [COORD_BITS-1:0] s_ax,
    input  wire  signed [COORD_BITS-1:0] s_ay,
    input  wire  signed [COORD_BITS-1:0] s_bx,
    input  wire  signed [COORD_BITS-1:0] s_by,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_visible,
    output logic                         m_degenerate,
    output logic                         m_table_full,
    output logic [CNT_W-1:0]             m_wall_count
);

    localparam int CW = COORD_BITS;

    // wall memory, {end_y, end_x, start_y, start_x}
    logic [WALL_W-1:0] wall_mem [0:MAX_WALLS-1];
    logic [WALL_W-1:0] rdata_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] walls_stored_reg;
    logic [CNT_W-1:0] rd_idx_reg;

    // query segment
    logic signed [CW-1:0]     qx1_reg, qy1_reg;
    logic signed [CW-1:0]     qminx_reg, qmaxx_reg, qminy_reg, qmaxy_reg;
    logic signed [DIFF_W-1:0] dqx_reg, dqy_reg;
    logic                     q_vis_reg, q_deg_reg;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 2: differences and box overlap
    logic signed [DIFF_W-1:0] dwx_reg, dwy_reg, ox_reg, oy_reg;
    logic                     box2_reg, box3_reg, box4_reg;

    // stage 3: products
    logic signed [PROD_W-1:0] p_dwy_dqx_reg, p_dwx_dqy_reg, p_dwx_oy_reg;
    logic signed [PROD_W-1:0] p_dwy_ox_reg, p_dqx_oy_reg, p_dqy_ox_reg;

    // stage 4: cross products
    logic signed [ACC_W-1:0] denom_reg, numa_reg, numb_reg;

    // output register
    logic             m_valid_reg;
    logic             m_visible_reg, m_degenerate_reg, m_table_full_reg;
    logic [CNT_W-1:0] m_wall_count_reg;

    // control
    logic accept, out_free, rd_en, hit, colin, scan_done, load_query;
    logic pipe_busy;

    function automatic logic in_range(input logic signed [ACC_W-1:0] v,
                                      input logic signed [ACC_W-1:0] d);
        if (d > 0) begin
            return (v >= 0) && (v <= d);
        end
        return (v <= 0) && (v >= d);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // crossing decision on the last stage
    assign hit   = v4_reg && (denom_reg != '0)
                   && in_range(numa_reg, denom_reg) && in_range(numb_reg, denom_reg);
    assign colin = v4_reg && (denom_reg == '0) && (numa_reg == '0)
                   && (numb_reg == '0) && box4_reg;

    assign scan_done = hit || ((rd_idx_reg == walls_stored_reg) && !pipe_busy);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        load_query = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
            end
            ST_SCAN: begin
                rd_en = (rd_idx_reg < walls_stored_reg) && !hit;
            end
            ST_FINISH: begin
                load_query = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // table count and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walls_stored_reg <= '0;
            rd_idx_reg       <= '0;
        end else begin
            if (accept && (s_op == OP_CLEAR)) begin
                walls_stored_reg <= '0;
            end else if (accept && (s_op == OP_APPEND)
                         && (walls_stored_reg < CNT_W'(MAX_WALLS))) begin
                walls_stored_reg <= walls_stored_reg + 1'b1;
            end
            if (accept) begin
                rd_idx_reg <= '0;
            end else if (rd_en) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // wall memory port
    always_ff @(posedge aclk) begin
        if (accept && (s_op == OP_APPEND) && (walls_stored_reg < CNT_W'(MAX_WALLS))) begin
            wall_mem[walls_stored_reg[ADDR_W-1:0]] <= {s_by, s_bx, s_ay, s_ax};
        end
        if (rd_en) begin
            rdata_reg <= wall_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    // query segment capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            qx1_reg   <= s_ax;
            qy1_reg   <= s_ay;
            qminx_reg <= (s_ax < s_bx) ? s_ax : s_bx;
            qmaxx_reg <= (s_ax < s_bx) ? s_bx : s_ax;
            qminy_reg <= (s_ay < s_by) ? s_ay : s_by;
            qmaxy_reg <= (s_ay < s_by) ? s_by : s_ay;
            dqx_reg   <= sub_ext(s_bx, s_ax);
            dqy_reg   <= sub_ext(s_by, s_ay);
        end
    end

    // pipeline valids, flushed on a crossing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (hit) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // crossing datapath
    always_ff @(posedge aclk) begin
        logic signed [CW-1:0] x3, y3, x4, y4;
        logic xo, yo;
        x3 = rdata_reg[CW-1:0];
        y3 = rdata_reg[2*CW-1:CW];
        x4 = rdata_reg[3*CW-1:2*CW];
        y4 = rdata_reg[4*CW-1:3*CW];
        xo = ((qminx_reg <= x3) || (qminx_reg <= x4)) && ((x3 <= qmaxx_reg) || (x4 <= qmaxx_reg));
        yo = ((qminy_reg <= y3) || (qminy_reg <= y4)) && ((y3 <= qmaxy_reg) || (y4 <= qmaxy_reg));

        dwx_reg  <= sub_ext(x4, x3);
        dwy_reg  <= sub_ext(y4, y3);
        ox_reg   <= sub_ext(qx1_reg, x3);
        oy_reg   <= sub_ext(qy1_reg, y3);
        box2_reg <= xo && yo;

        p_dwy_dqx_reg <= dwy_reg * dqx_reg;
        p_dwx_dqy_reg <= dwx_reg * dqy_reg;
        p_dwx_oy_reg  <= dwx_reg * oy_reg;
        p_dwy_ox_reg  <= dwy_reg * ox_reg;
        p_dqx_oy_reg  <= dqx_reg * oy_reg;
        p_dqy_ox_reg  <= dqy_reg * ox_reg;
        box3_reg      <= box2_reg;

        denom_reg <= ACC_W'(p_dwy_dqx_reg) - ACC_W'(p_dwx_dqy_reg);
        numa_reg  <= ACC_W'(p_dwx_oy_reg) - ACC_W'(p_dwy_ox_reg);
        numb_reg  <= ACC_W'(p_dqx_oy_reg) - ACC_W'(p_dqy_ox_reg);
        box4_reg  <= box3_reg;
    end

    // query flags
    always_ff @(posedge aclk) begin
        if (accept) begin
            q_vis_reg <= 1'b1;
            q_deg_reg <= 1'b0;
        end else begin
            if (hit) begin
                q_vis_reg <= 1'b0;
            end
            if (colin) begin
                q_deg_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && (s_op != OP_QUERY)) begin
            m_valid_reg <= 1'b1;
        end else if (load_query) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_op != OP_QUERY)) begin
            m_visible_reg    <= 1'b0;
            m_degenerate_reg <= 1'b0;
            m_table_full_reg <= (s_op == OP_APPEND) && (walls_stored_reg >= CNT_W'(MAX_WALLS));
            case (s_op)
                OP_CLEAR:  m_wall_count_reg <= '0;
                OP_APPEND: m_wall_count_reg <= (walls_stored_reg < CNT_W'(MAX_WALLS))
                                               ? walls_stored_reg + 1'b1 : walls_stored_reg;
                default:   m_wall_count_reg <= walls_stored_reg;
            endcase
        end else if (load_query) begin
            m_visible_reg    <= q_vis_reg;
            m_degenerate_reg <= q_deg_reg;
            m_table_full_reg <= 1'b0;
            m_wall_count_reg <= walls_stored_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_visible    = m_visible_reg;
    assign m_degenerate = m_degenerate_reg;
    assign m_table_full = m_table_full_reg;
    assign m_wall_count = m_wall_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        walls_stored_reg <= CNT_W'(MAX_WALLS))
        else $error("wall count above table size");

    a_read_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_idx_reg < walls_stored_reg))
        else $error("scan read past stored walls");

    a_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> !(v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("crossing pipeline busy outside scan");

    a_hit_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |=> (state_reg == ST_FINISH) && !q_vis_reg)
        else $error("crossing did not end the scan");

    a_no_take_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_ready && !load_query)
        else $error("new beat or result during scan");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-of-sight obstacle check core. A directed
// list of clear, append, query and unused-op beats comes first, then random
// wall sessions under changing back-pressure. Results are scored against a
// bench-side wall table copy and segment crossing test, or directed values.
// ----------------------------------------------------------------------------
module tb_top;
    import losoc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int C_MAX           = (1 << (COORD_BITS - 1)) - 1;
    localparam int C_MIN           = -C_MAX - 1;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 40;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] op;
        coord_t     ax;
        coord_t     ay;
        coord_t     bx;
        coord_t     by;
    } cmd_t;

    typedef struct packed {
        logic             visible;
        logic             degenerate;
        logic             table_full;
        logic [CNT_W-1:0] wall_count;
    } sight_t;

    typedef struct {
        cmd_t   cmd;
        bit     typed;
        sight_t res;
    } row_t;

    typedef enum {SEG_APART, SEG_CROSS, SEG_OVERLAP} seg_rel_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_valid  = 1'b0;
    logic             s_ready;
    logic [1:0]       s_op     = OP_CLEAR;
    coord_t           s_ax     = '0;
    coord_t           s_ay     = '0;
    coord_t           s_bx     = '0;
    coord_t           s_by     = '0;
    logic             m_valid;
    logic             m_ready  = 1'b0;
    logic             m_visible;
    logic             m_degenerate;
    logic             m_table_full;
    logic [CNT_W-1:0] m_wall_count;

    cmd_t   wall_tab[MAX_WALLS];
    int     walls_held   = 0;
    sight_t sight_expected[$];
    row_t   dir_rows[$];
    int     items_sent   = 0;
    int     mismatches   = 0;
    int     send_idle    = 0;
    int     recv_idle    = 0;
    bit     hold_req     = 1'b0;
    int     hold_left    = 0;
    int     quiet_cycles = 0;

    always #5 aclk = ~aclk;

    line_of_sight_obstacle_check_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_visible    (m_visible),
        .m_degenerate (m_degenerate),
        .m_table_full (m_table_full),
        .m_wall_count (m_wall_count)
    );

    function automatic longint sx(coord_t v);
        return v;
    endfunction

    function automatic longint lo(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint hi(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // v / d lies in [0,1] without dividing
    function automatic bit in_span(longint v, longint d);
        if (d > 0) begin
            return v >= 0 && v <= d;
        end
        return v <= 0 && v >= d;
    endfunction

    function automatic seg_rel_t seg_relation(cmd_t q, cmd_t w);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint denom, numa, numb;
        bit     x_meet, y_meet;
        x1 = sx(q.ax); y1 = sx(q.ay); x2 = sx(q.bx); y2 = sx(q.by);
        x3 = sx(w.ax); y3 = sx(w.ay); x4 = sx(w.bx); y4 = sx(w.by);
        denom = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
        numa  = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
        numb  = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
        if (denom != 0) begin
            return (in_span(numa, denom) && in_span(numb, denom)) ? SEG_CROSS : SEG_APART;
        end
        // parallel but offset
        if (numa != 0 || numb != 0) begin
            return SEG_APART;
        end
        x_meet = lo(x1, x2) <= hi(x3, x4) && lo(x3, x4) <= hi(x1, x2);
        y_meet = lo(y1, y2) <= hi(y3, y4) && lo(y3, y4) <= hi(y1, y2);
        return (x_meet && y_meet) ? SEG_OVERLAP : SEG_APART;
    endfunction

    function automatic sight_t compute_sight(cmd_t c);
        sight_t   r;
        seg_rel_t rel;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                walls_held = 0;
            end
            OP_APPEND: begin
                if (walls_held >= MAX_WALLS) begin
                    r.table_full = 1'b1;
                end else begin
                    wall_tab[walls_held] = c;
                    walls_held++;
                end
            end
            OP_QUERY: begin
                r.visible = 1'b1;
                for (int i = 0; i < walls_held; i++) begin
                    rel = seg_relation(c, wall_tab[i]);
                    if (rel == SEG_CROSS) begin
                        r.visible = 1'b0;
                        break;
                    end
                    if (rel == SEG_OVERLAP) begin
                        r.degenerate = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.wall_count = CNT_W'(walls_held);
        return r;
    endfunction

    function automatic row_t row(logic [1:0] op, int ax, int ay, int bx, int by,
                                 bit typed = 1'b0, bit vis = 1'b0, bit deg = 1'b0,
                                 bit full = 1'b0, int count = 0);
        row_t r;
        r.cmd          = '{op, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by)};
        r.typed        = typed;
        r.res          = '{vis, deg, full, CNT_W'(count)};
        return r;
    endfunction

    // append one row to the directed list
    function automatic void add_row(row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic coord_t rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return coord_t'(int'($urandom_range(40)) - 20);
        end
        if (pick < 85) begin
            return coord_t'($urandom);
        end
        case ($urandom_range(3))
            0: return coord_t'(C_MIN);
            1: return coord_t'(C_MAX);
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic cmd_t rand_cmd(logic [1:0] op);
        cmd_t c;
        c.op = op;
        c.ax = rand_coord();
        c.ay = rand_coord();
        c.bx = rand_coord();
        c.by = rand_coord();
        return c;
    endfunction

    // query built on a stored wall: same line, shared endpoints, zero length
    function automatic cmd_t near_wall(cmd_t w);
        cmd_t   c;
        coord_t dx, dy;
        dx   = w.bx - w.ax;
        dy   = w.by - w.ay;
        c    = w;
        c.op = OP_QUERY;
        case ($urandom_range(5))
            0: begin
            end
            1: begin
                c.ax = w.bx; c.ay = w.by; c.bx = w.ax; c.by = w.ay;
            end
            2: begin
                c.ax = w.ax - dx; c.ay = w.ay - dy; c.bx = w.ax; c.by = w.ay;
            end
            3: begin
                c.ax = w.bx; c.ay = w.by; c.bx = w.bx + dx; c.by = w.by + dy;
            end
            4: begin
                c.bx = w.ax; c.by = w.ay;
            end
            default: begin
                c.ax = w.bx; c.ay = w.by; c.bx = rand_coord(); c.by = rand_coord();
            end
        endcase
        return c;
    endfunction

    task automatic offer(cmd_t c, bit typed = 1'b0, sight_t res = '0);
        sight_t want;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= c.op;
        s_ax    <= c.ax;
        s_ay    <= c.ay;
        s_bx    <= c.bx;
        s_by    <= c.by;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = compute_sight(c);
        sight_expected.insert(sight_expected.size(), typed ? res : want);
        items_sent++;
    endtask

    task automatic sender_pause();
        s_valid <= 1'b0;
        while (sight_expected.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic wall_session();
        int n_walls;
        int n_queries;
        // noise: any op, unrelated coordinates
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 4)) offer(rand_cmd(2'($urandom_range(3))));
            return;
        end
        if ($urandom_range(99) < 90) begin
            offer(rand_cmd(OP_CLEAR));
        end
        n_walls = $urandom_range(10);
        repeat (n_walls) offer(rand_cmd(OP_APPEND));
        n_queries = $urandom_range(1, 6);
        repeat (n_queries) begin
            case ($urandom_range(19))
                0: offer(rand_cmd(OP_APPEND));
                1: offer(rand_cmd(OP_UNUSED));
                2, 3, 4, 5: begin
                    if (walls_held > 0) begin
                        offer(near_wall(wall_tab[$urandom_range(walls_held - 1)]));
                    end else begin
                        offer(rand_cmd(OP_QUERY));
                    end
                end
                default: offer(rand_cmd(OP_QUERY));
            endcase
        end
    endtask

    task automatic full_table_session();
        cmd_t far_q;
        offer(rand_cmd(OP_CLEAR));
        repeat (MAX_WALLS) offer(rand_cmd(OP_APPEND));
        // appends past the end are dropped
        repeat (3) offer(rand_cmd(OP_APPEND));
        repeat (3) offer(rand_cmd(OP_QUERY));
        offer(near_wall(wall_tab[MAX_WALLS - 1]));
        far_q = '{OP_QUERY, coord_t'(400000), coord_t'(400000),
                  coord_t'(400001), coord_t'(-400000)};
        offer(far_q);
        offer(rand_cmd(OP_CLEAR));
    endtask

    task automatic run_phase(int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota) wall_session();
    endtask

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result beat scoring
    always @(posedge aclk) begin
        sight_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sight_expected.size() == 0) begin
                $display("%0t ns: result beat with nothing expected", $time);
                mismatches++;
            end else begin
                want = sight_expected.pop_front();
                check_field("visible", CNT_W'(want.visible), CNT_W'(m_visible));
                check_field("degenerate", CNT_W'(want.degenerate), CNT_W'(m_degenerate));
                check_field("table_full", CNT_W'(want.table_full), CNT_W'(m_table_full));
                check_field("wall_count", want.wall_count, m_wall_count);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t ns: no beat for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        add_row(row(OP_QUERY, 0, 0, 10, 10, 1, 1, 0, 0, 0));
        add_row(row(OP_UNUSED, C_MAX, C_MIN, -1, 1, 1, 0, 0, 0, 0));
        add_row(row(OP_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        add_row(row(OP_APPEND, 0, -10, 0, 10, 1, 0, 0, 0, 1));
        add_row(row(OP_QUERY, -10, 0, 10, 0));
        // parallel, offset
        add_row(row(OP_QUERY, 5, -10, 5, 10));
        // same line, overlapping
        add_row(row(OP_QUERY, 0, 5, 0, 20));
        // touches the wall end
        add_row(row(OP_QUERY, -10, 10, 10, 10));
        // same line, apart
        add_row(row(OP_QUERY, 0, 11, 0, 30));
        add_row(row(OP_APPEND, 3, 3, 3, 3, 1, 0, 0, 0, 2));
        add_row(row(OP_QUERY, 1, 1, 6, 6));
        add_row(row(OP_APPEND, C_MIN, C_MIN, C_MAX, C_MAX, 1, 0, 0, 0, 3));
        add_row(row(OP_QUERY, C_MIN, C_MAX, C_MAX, C_MIN));
        add_row(row(OP_QUERY, C_MAX, C_MAX, C_MAX, C_MAX));
        add_row(row(OP_QUERY, -1, -1, C_MIN, 0));
        add_row(row(OP_QUERY, 3, 3, 3, 3));
        add_row(row(OP_CLEAR, C_MAX, C_MAX, C_MIN, C_MIN, 1, 0, 0, 0, 0));
        add_row(row(OP_QUERY, C_MIN, C_MIN, C_MAX, C_MAX, 1, 1, 0, 0, 0));
        add_row(row(OP_APPEND, -1, -1, -1, -1, 1, 0, 0, 0, 1));
        add_row(row(OP_UNUSED, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        add_row(row(OP_QUERY, -1, 0, -1, -2));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) offer(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
        sender_pause();

        // sender mostly busy, receiver mostly stalled, one long hold-off up front
        send_idle = 10;
        recv_idle = 80;
        hold_req  = 1'b1;
        run_phase(430);
        sender_pause();

        send_idle = 80;
        recv_idle = 10;
        run_phase(430);
        sender_pause();

        send_idle = 0;
        recv_idle = 0;
        full_table_session();
        run_phase(380);
        sender_pause();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
